@@ sv/wfur_pkg.sv @@
// Shared types and constants for the WebSocket frame unmask and reframe block.
// Depends on nothing; used by the front parser, the command queue, the beat generator, the top level and the checker.
package wfur_pkg;

  localparam int QDEPTH = 4;

  localparam logic [7:0] FIN_BIT     = 8'h80;
  localparam logic [6:0] LEN16_CODE  = 7'd126;
  localparam logic [6:0] LEN64_CODE  = 7'd127;
  localparam logic [6:0] SHORT_MAX   = 7'd125;
  localparam logic [3:0] OPC_CLOSE   = 4'h8;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_DROP  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_HDR   = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_DROP  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data;
    logic        last;
    logic        hdr_short;
    logic [15:0] len;
  } cmd_t;

endpackage

@@ sv/wfur_front.sv @@
// Front parser: accepts input bytes, tracks the frame header and turns frames into commands.
// Depends on wfur_pkg.
module wfur_front #(
  parameter longint unsigned MAX_RELAY_PAYLOAD = 65535
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  output logic           cmd_valid,
  output wfur_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    PH_FIRST   = 7'b0000001,
    PH_SECOND  = 7'b0000010,
    PH_EXTLEN  = 7'b0000100,
    PH_MASK    = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_SKIP    = 7'b0100000,
    PH_CLOSED  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        mask_present, mask_present_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [63:0] payload_length, payload_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  payload_index, payload_index_next;
  logic [63:0] remaining, remaining_next;

  logic        hd;
  logic [63:0] hd_len;
  logic [7:0]  key_byte;
  logic [3:0]  cnt_dec;

  assign cnt_dec = field_byte_count - 4'd1;

  always_comb begin
    case (payload_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!mask_present) begin
      key_byte = 8'd0;
    end
  end

  always_comb begin
    phase_next            = phase;
    frame_opcode_next     = frame_opcode;
    mask_present_next     = mask_present;
    field_byte_count_next = field_byte_count;
    payload_length_next   = payload_length;
    mask_key_next         = mask_key;
    payload_index_next    = payload_index;
    remaining_next        = remaining;
    hd                    = 1'b0;
    hd_len                = payload_length;
    cmd_valid             = 1'b0;
    cmd                   = '0;
    cmd.op                = wfur_pkg::CMD_DATA;
    unique case (phase)
      PH_FIRST: begin
        frame_opcode_next = in_byte[3:0];
        if (in_byte[3:0] == wfur_pkg::OPC_CLOSE) begin
          cmd_valid  = 1'b1;
          cmd.op     = wfur_pkg::CMD_CLOSE;
          cmd.last   = 1'b1;
          phase_next = PH_CLOSED;
        end else begin
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        mask_present_next   = in_byte[7];
        mask_key_next       = '0;
        payload_length_next = '0;
        if (in_byte[6:0] == wfur_pkg::LEN16_CODE || in_byte[6:0] == wfur_pkg::LEN64_CODE) begin
          field_byte_count_next = (in_byte[6:0] == wfur_pkg::LEN16_CODE) ?
                                  wfur_pkg::EXT16_BYTES : wfur_pkg::EXT64_BYTES;
          phase_next = PH_EXTLEN;
        end else begin
          payload_length_next = {57'd0, in_byte[6:0]};
          hd_len              = {57'd0, in_byte[6:0]};
          if (in_byte[7]) begin
            field_byte_count_next = wfur_pkg::KEY_BYTES;
            phase_next            = PH_MASK;
          end else begin
            field_byte_count_next = '0;
            hd                    = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        payload_length_next   = {payload_length[55:0], in_byte};
        hd_len                = {payload_length[55:0], in_byte};
        field_byte_count_next = cnt_dec;
        if (cnt_dec == 4'd0) begin
          if (mask_present) begin
            field_byte_count_next = wfur_pkg::KEY_BYTES;
            phase_next            = PH_MASK;
          end else begin
            hd = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_next         = {mask_key[23:0], in_byte};
        field_byte_count_next = cnt_dec;
        if (cnt_dec == 4'd0) begin
          hd = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        cmd_valid          = 1'b1;
        cmd.op             = wfur_pkg::CMD_DATA;
        cmd.data           = in_byte ^ key_byte;
        cmd.last           = (remaining == 64'd1);
        payload_index_next = payload_index + 2'd1;
        remaining_next     = remaining - 64'd1;
        if (remaining == 64'd1) begin
          phase_next = PH_FIRST;
        end
      end
      PH_SKIP: begin
        remaining_next = remaining - 64'd1;
        if (remaining == 64'd1) begin
          phase_next = PH_FIRST;
        end
      end
      PH_CLOSED: begin
        phase_next = PH_CLOSED;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase

    if (hd) begin
      payload_index_next = '0;
      remaining_next     = hd_len;
      cmd_valid          = 1'b1;
      if (hd_len > 64'(MAX_RELAY_PAYLOAD)) begin
        cmd.op     = wfur_pkg::CMD_DROP;
        cmd.last   = 1'b1;
        phase_next = PH_SKIP;
      end else begin
        cmd.op        = wfur_pkg::CMD_HDR;
        cmd.data      = {4'd0, frame_opcode};
        cmd.hdr_short = (hd_len <= 64'(wfur_pkg::SHORT_MAX));
        cmd.len       = hd_len[15:0];
        phase_next    = (hd_len == 64'd0) ? PH_FIRST : PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_FIRST;
      frame_opcode     <= '0;
      mask_present     <= 1'b0;
      field_byte_count <= '0;
      payload_length   <= '0;
      mask_key         <= '0;
      payload_index    <= '0;
      remaining        <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      frame_opcode     <= frame_opcode_next;
      mask_present     <= mask_present_next;
      field_byte_count <= field_byte_count_next;
      payload_length   <= payload_length_next;
      mask_key         <= mask_key_next;
      payload_index    <= payload_index_next;
      remaining        <= remaining_next;
    end
  end

endmodule

@@ sv/wfur_queue.sv @@
// Short command queue between the front parser and the beat generator.
// Depends on wfur_pkg for the command type and the queue depth.
module wfur_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wfur_pkg::cmd_t push_cmd,
  input  logic           pop,
  output wfur_pkg::cmd_t head,
  output logic           nonempty,
  output logic           full
);

  localparam int PW = $clog2(wfur_pkg::QDEPTH);
  localparam int CW = $clog2(wfur_pkg::QDEPTH + 1);

  wfur_pkg::cmd_t entries [wfur_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head     = entries[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == CW'(wfur_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(wfur_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(wfur_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/wfur_back.sv @@
// Beat generator: expands queued commands into result beats held in an output register.
// Depends on wfur_pkg.
module wfur_back (
  input  logic           clk,
  input  logic           rst,
  input  wfur_pkg::cmd_t head,
  input  logic           head_valid,
  output logic           head_done,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic [1:0]     kind,
  output logic           last
);

  logic       out_valid;
  logic [1:0] beat;
  logic       load;
  logic       final_beat;
  logic [7:0] byte_next;
  logic [1:0] kind_next;
  logic       last_next;

  assign load      = head_valid && (!out_valid || pop);
  assign head_done = load && final_beat;
  assign empty     = !out_valid;

  always_comb begin
    byte_next  = 8'd0;
    kind_next  = wfur_pkg::KIND_FRAME;
    last_next  = 1'b1;
    final_beat = 1'b1;
    unique case (head.op)
      wfur_pkg::CMD_DATA: begin
        byte_next = head.data;
        last_next = head.last;
      end
      wfur_pkg::CMD_DROP: begin
        kind_next = wfur_pkg::KIND_DROP;
      end
      wfur_pkg::CMD_CLOSE: begin
        kind_next = wfur_pkg::KIND_CLOSE;
      end
      wfur_pkg::CMD_HDR: begin
        last_next  = 1'b0;
        final_beat = 1'b0;
        case (beat)
          2'd0: begin
            byte_next = wfur_pkg::FIN_BIT | head.data;
          end
          2'd1: begin
            if (head.hdr_short) begin
              byte_next  = head.len[7:0];
              last_next  = (head.len == 16'd0);
              final_beat = 1'b1;
            end else begin
              byte_next = {1'b0, wfur_pkg::LEN16_CODE};
            end
          end
          2'd2: begin
            byte_next = head.len[15:8];
          end
          default: begin
            byte_next  = head.len[7:0];
            final_beat = 1'b1;
          end
        endcase
      end
      default: begin
        last_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      kind     <= kind_next;
      last     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat      <= final_beat ? 2'd0 : beat + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/websocket_frame_unmask_reframe.sv @@
// WebSocket frame unmask and reframe: parses client frames byte by byte and emits server frames.
// A result beat is registered first in the command queue and then in the output register.
// Throughput: one input byte per cycle while the queue is not full; the beat generator expands
// a relayed header into its first byte and a short or 16-bit extended length, one beat per cycle while beats are taken.
// Reset is synchronous; it clears the parser and the command queue and empties the output register.
// Depends on wfur_pkg, wfur_front, wfur_queue and wfur_back.
module websocket_frame_unmask_reframe #(
  parameter longint unsigned MAX_RELAY_PAYLOAD = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  logic           accept;
  logic           cmd_valid;
  wfur_pkg::cmd_t cmd;
  wfur_pkg::cmd_t head;
  logic           head_valid;
  logic           head_done;

  assign accept = push && !full;

  wfur_front #(
    .MAX_RELAY_PAYLOAD(MAX_RELAY_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  wfur_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && cmd_valid),
    .push_cmd (cmd),
    .pop      (head_done),
    .head     (head),
    .nonempty (head_valid),
    .full     (full)
  );

  wfur_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_done  (head_done),
    .pop        (pop && !empty),
    .empty      (empty),
    .out_byte   (out_byte),
    .kind       (kind),
    .last       (last)
  );

endmodule

@@ sv/wfur_checker.sv @@
// Port-level checks for the WebSocket frame unmask and reframe block, and their binding.
// Depends on the top level's ports and on wfur_pkg for the result kinds.
module wfur_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic       last
);

  a_empty_after_reset: assert property (@(posedge clk) (rst ##1 rst) |=> empty)
    else $error("Result waiting straight after reset.");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind == wfur_pkg::KIND_FRAME || kind == wfur_pkg::KIND_DROP ||
                kind == wfur_pkg::KIND_CLOSE))
    else $error("Unknown result kind.");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != wfur_pkg::KIND_FRAME) |-> (last && out_byte == 8'd0))
    else $error("Status beat is not a lone zero beat.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(kind) && $stable(last)))
    else $error("Waiting result changed before it was taken.");

endmodule

bind websocket_frame_unmask_reframe wfur_checker u_wfur_checker (
  .clk      (clk),
  .rst      (rst),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .kind     (kind),
  .last     (last)
);
